### hw/rtl/css_pkg.sv
`timescale 1ns / 1ps

package css_pkg;

    // Default sizes
    localparam int NODES_DEF     = 256;
    localparam int STATIONS_DEF  = 32;
    localparam int DIST_BITS_DEF = 24;

    // Fixed field widths
    localparam int NODE_W      = 8;
    localparam int DIST_W      = 24;
    localparam int SLOT_W      = 5;
    localparam int CMD_W       = 3;
    localparam int COST_OUT_W  = 25;
    localparam int COUNT_W     = 6;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_STATION_COUNT = 1'b0;
    localparam logic REG_MAX_RANGE     = 1'b1;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST = '1;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_LOAD_DIST = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_STN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DETOUR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FEASIBLE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEAREST   = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_DIST,
        OP_LOAD_STN,
        OP_DETOUR,
        OP_FEASIBLE,
        OP_NEAREST
    } css_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } css_bk_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [DIST_W-1:0] distance_value;
        logic [SLOT_W-1:0] station_slot;
        logic [NODE_W-1:0] station_id;
        logic [DIST_W-1:0] limit;
    } css_in_t;

    typedef struct packed {
        logic                  found;
        logic [NODE_W-1:0]     best_station;
        logic [COST_OUT_W-1:0] best_cost;
    } css_out_t;

    typedef struct packed {
        css_op_t           op;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [DIST_W-1:0] distance_value;
        logic [SLOT_W-1:0] station_slot;
        logic [NODE_W-1:0] station_id;
        logic [DIST_W-1:0] limit;
        logic              slot_ok;
    } css_job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] station_count;
        logic [DIST_W-1:0]  max_range;
    } css_cfg_t;

endpackage

### hw/rtl/css_front.sv
`timescale 1ns / 1ps

module css_front #(
    parameter int STATIONS = css_pkg::STATIONS_DEF
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  css_pkg::css_in_t  s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output css_pkg::css_job_t q_job
);

    // Pass the handshake straight to the queue
    assign q_valid = s_valid;
    assign s_ready = q_ready;

    // Classify the command and check the station slot
    always_comb begin
        unique case (s_data.command)
            css_pkg::CMD_LOAD_DIST: q_job.op = css_pkg::OP_LOAD_DIST;
            css_pkg::CMD_LOAD_STN:  q_job.op = css_pkg::OP_LOAD_STN;
            css_pkg::CMD_DETOUR:    q_job.op = css_pkg::OP_DETOUR;
            css_pkg::CMD_FEASIBLE:  q_job.op = css_pkg::OP_FEASIBLE;
            css_pkg::CMD_NEAREST:   q_job.op = css_pkg::OP_NEAREST;
            default:                q_job.op = css_pkg::OP_NONE;
        endcase
        q_job.from_node      = s_data.from_node;
        q_job.to_node        = s_data.to_node;
        q_job.distance_value = s_data.distance_value;
        q_job.station_slot   = s_data.station_slot;
        q_job.station_id     = s_data.station_id;
        q_job.limit          = s_data.limit;
        q_job.slot_ok        = 32'(s_data.station_slot) < 32'(STATIONS);
    end

endmodule

### hw/rtl/css_queue.sv
`timescale 1ns / 1ps

module css_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  css_pkg::css_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output css_pkg::css_job_t out_job
);

    localparam int DEPTH = css_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    css_pkg::css_job_t ent_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CNTW-1:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != CNTW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_job   = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold queued items
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

### hw/rtl/css_back.sv
`timescale 1ns / 1ps

module css_back #(
    parameter int NODES     = css_pkg::NODES_DEF,
    parameter int STATIONS  = css_pkg::STATIONS_DEF,
    parameter int DIST_BITS = css_pkg::DIST_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  css_pkg::css_cfg_t cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  css_pkg::css_job_t job,
    output logic              m_valid,
    input  logic              m_ready,
    output css_pkg::css_out_t m_data
);

    localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int MW     = NW + 9;
    localparam int AW     = $clog2(NODES * NODES);
    localparam int SW     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int KW     = $clog2(STATIONS + 1);
    localparam int NCW    = (KW > css_pkg::COUNT_W) ? KW : css_pkg::COUNT_W;
    localparam int SEW    = css_pkg::NODE_W + NW;
    localparam int CW     = (DIST_BITS > css_pkg::DIST_W) ? DIST_BITS : css_pkg::DIST_W;
    localparam int COST_W = DIST_BITS + 1;
    localparam int OCW    = (COST_W > css_pkg::COST_OUT_W) ? COST_W : css_pkg::COST_OUT_W;

    // Reduce a node number to a table index, one conditional subtract per bit
    function automatic logic [NW-1:0] node_idx(input logic [css_pkg::NODE_W-1:0] v);
        logic [MW-1:0] r;
        r = MW'(v);
        for (int i = css_pkg::NODE_W - 1; i >= 0; i--) begin
            if (r >= (MW'(NODES) << i)) begin
                r = r - (MW'(NODES) << i);
            end
        end
        return r[NW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
        return AW'(row) * AW'(NODES) + AW'(col);
    endfunction

    // Storage
    logic [DIST_BITS-1:0] dist_mem [NODES * NODES];
    logic [SEW-1:0]       stn_mem  [STATIONS];

    css_pkg::css_bk_state_t state_reg, state_next;

    css_pkg::css_op_t           op_reg;
    logic [css_pkg::NODE_W-1:0] from_raw_reg;
    logic [css_pkg::NODE_W-1:0] to_raw_reg;
    logic [NW-1:0]              from_idx_reg;
    logic [NW-1:0]              to_idx_reg;
    logic [css_pkg::DIST_W-1:0] limit_reg;
    logic [KW-1:0]              n_reg;
    logic [KW-1:0]              k_reg;

    logic                       p1_v_reg;
    logic                       p1_sub_reg;
    logic [SEW-1:0]             stn_rd_reg;
    logic [DIST_BITS-1:0]       rd_a_reg;
    logic [DIST_BITS-1:0]       rd_b_reg;
    logic                       p2_v_reg;
    logic                       p2_sub_reg;
    logic [css_pkg::NODE_W-1:0] p2_stn_reg;
    logic [DIST_BITS-1:0]       hold_a_reg;
    logic [DIST_BITS-1:0]       hold_b_reg;

    logic                       found_reg;
    logic [css_pkg::NODE_W-1:0] best_stn_reg;
    logic [COST_W-1:0]          best_cost_reg;
    logic                       m_valid_reg;
    css_pkg::css_out_t          m_data_reg;

    logic                       pop;
    logic                       is_query;
    logic [KW-1:0]              n_new;
    logic                       feas;
    logic                       issue;
    logic                       p1_v_next;
    logic                       scan_done;
    logic                       out_free;
    logic                       out_load;
    logic [NW-1:0]              s_idx;
    logic                       b_fwd;
    logic [AW-1:0]              addr_a;
    logic [AW-1:0]              addr_b;
    logic                       dist_we;
    logic [AW-1:0]              dist_waddr;
    logic                       stn_we;
    logic [SW-1:0]              stn_waddr;
    logic                       eval;
    logic [DIST_BITS-1:0]       dfs;
    logic [DIST_BITS-1:0]       d2;
    logic [COST_W-1:0]          cand_cost;
    logic                       not_end;
    logic                       ok;
    logic                       take;
    logic [OCW-1:0]             cost_ext;

    // Job intake and clamped station count
    assign job_ready = state_reg == css_pkg::BK_IDLE;
    assign pop       = job_valid && job_ready;
    assign is_query  = job.op == css_pkg::OP_DETOUR || job.op == css_pkg::OP_FEASIBLE ||
                       job.op == css_pkg::OP_NEAREST;
    assign n_new     = (NCW'(cfg.station_count) > NCW'(STATIONS)) ? KW'(STATIONS)
                                                                  : KW'(cfg.station_count);

    // Issue one station a cycle; the feasible detour holds the issue for a second read pass of each station
    assign feas      = op_reg == css_pkg::OP_FEASIBLE;
    assign issue     = (state_reg == css_pkg::BK_SCAN) && (k_reg < n_reg) &&
                       !(feas && p1_v_reg && !p1_sub_reg);
    assign p1_v_next = issue || (feas && p1_v_reg && !p1_sub_reg);
    assign scan_done = (k_reg >= n_reg) && !p1_v_reg && !p2_v_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Distance read addresses
    assign s_idx  = stn_rd_reg[NW-1:0];
    assign b_fwd  = op_reg == css_pkg::OP_NEAREST || (feas && p1_sub_reg);
    assign addr_a = addr_of(from_idx_reg, s_idx);
    assign addr_b = b_fwd ? addr_of(s_idx, to_idx_reg) : addr_of(to_idx_reg, s_idx);

    // Load writes
    assign dist_we    = pop && job.op == css_pkg::OP_LOAD_DIST;
    assign dist_waddr = addr_of(node_idx(job.from_node), node_idx(job.to_node));
    assign stn_we     = pop && job.op == css_pkg::OP_LOAD_STN && job.slot_ok;
    assign stn_waddr  = SW'(job.station_slot);

    // Candidate check and cost
    assign eval      = p2_v_reg && (!feas || p2_sub_reg);
    assign dfs       = feas ? hold_a_reg : rd_a_reg;
    assign d2        = feas ? hold_b_reg : rd_b_reg;
    assign cand_cost = (op_reg == css_pkg::OP_NEAREST) ? COST_W'(d2)
                                                       : COST_W'(dfs) + COST_W'(d2);
    assign not_end   = p2_stn_reg != from_raw_reg && p2_stn_reg != to_raw_reg;

    always_comb begin
        case (op_reg)
            css_pkg::OP_NEAREST:  ok = CW'(dfs) <= CW'(limit_reg);
            css_pkg::OP_DETOUR:   ok = not_end;
            css_pkg::OP_FEASIBLE: ok = not_end && (CW'(dfs) < CW'(limit_reg)) &&
                                       (CW'(rd_b_reg) < CW'(cfg.max_range));
            default:              ok = 1'b0;
        endcase
    end

    assign take = eval && ok && (!found_reg || cand_cost < best_cost_reg);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= css_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            css_pkg::BK_IDLE: begin
                if (pop) begin
                    state_next = is_query ? css_pkg::BK_SCAN : css_pkg::BK_DONE;
                end
            end
            css_pkg::BK_SCAN: begin
                if (scan_done) begin
                    state_next = css_pkg::BK_DONE;
                end
            end
            css_pkg::BK_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = css_pkg::BK_IDLE;
                end
            end
            default: state_next = css_pkg::BK_IDLE;
        endcase
    end

    // Pipeline valids, station counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            p1_v_reg <= p1_v_next;
            p2_v_reg <= p1_v_reg;
            if (pop) begin
                k_reg <= '0;
            end else if (issue) begin
                k_reg <= k_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Job fields, best choice and pipeline payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            op_reg        <= job.op;
            from_raw_reg  <= job.from_node;
            to_raw_reg    <= job.to_node;
            from_idx_reg  <= node_idx(job.from_node);
            to_idx_reg    <= node_idx(job.to_node);
            limit_reg     <= job.limit;
            n_reg         <= n_new;
            found_reg     <= 1'b0;
            best_stn_reg  <= '0;
            best_cost_reg <= '0;
        end else if (take) begin
            found_reg     <= 1'b1;
            best_stn_reg  <= p2_stn_reg;
            best_cost_reg <= cand_cost;
        end
        p1_sub_reg <= !issue;
        p2_sub_reg <= p1_sub_reg;
        p2_stn_reg <= stn_rd_reg[SEW-1:NW];
        if (p2_v_reg && feas && !p2_sub_reg) begin
            hold_a_reg <= rd_a_reg;
            hold_b_reg <= rd_b_reg;
        end
        if (out_load) begin
            m_data_reg.found        <= found_reg;
            m_data_reg.best_station <= best_stn_reg;
            m_data_reg.best_cost    <= cost_ext[css_pkg::COST_OUT_W-1:0];
        end
    end

    assign cost_ext = OCW'(best_cost_reg);

    // Distance table: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= DIST_BITS'(job.distance_value);
        end
        rd_a_reg <= dist_mem[addr_a];
        rd_b_reg <= dist_mem[addr_b];
    end

    // Station list: raw node number beside its table index
    always_ff @(posedge aclk) begin
        if (stn_we) begin
            stn_mem[stn_waddr] <= {job.station_id, node_idx(job.station_id)};
        end
        if (issue) begin
            stn_rd_reg <= stn_mem[k_reg[SW-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/charging_station_search.sv
`timescale 1ns / 1ps

// Charging station search.
// Input channel s_valid/s_ready/s_data carries one command item: distance
// load, station load, or one of three station queries. Every item yields
// exactly one result item on m_valid/m_ready/m_data, in order.
// Configuration (station_count at 0x0, max_range at 0x4) goes through the
// APB port and is to be written only while the block is idle; the block itself does not enforce this.
// Items pass a two-entry job queue before the execution unit, so the input
// side keeps accepting while the unit works or the result waits.
// A load or an unknown command skips the scan. A query scans n stations,
// n being the clamped station count. One station enters the scan per
// cycle, except in the feasible detour: the distance table has two read
// ports, and that query needs three distances per station. A new item
// enters the unit only once the last result has reached the output register.
// Reset (synchronous, aresetn low) empties the queue, drops any pending
// result and restores station_count to 0 and max_range to all ones. The
// distance table and station list keep whatever they held.
// A stalled receiver holds the result in the output register; the queue
// fills and then s_ready drops.

module charging_station_search #(
    parameter int NODES     = css_pkg::NODES_DEF,
    parameter int STATIONS  = css_pkg::STATIONS_DEF,
    parameter int DIST_BITS = css_pkg::DIST_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  css_pkg::css_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output css_pkg::css_out_t                m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [css_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [css_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [css_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [css_pkg::COUNT_W-1:0] station_count_reg;
    logic [css_pkg::DIST_W-1:0]  max_range_reg;
    logic                        reg_idx;
    logic                        q_in_valid;
    logic                        q_in_ready;
    css_pkg::css_job_t           q_in_job;
    logic                        q_out_valid;
    logic                        q_out_ready;
    css_pkg::css_job_t           q_out_job;
    css_pkg::css_cfg_t           cfg;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_count_reg <= '0;
            max_range_reg     <= css_pkg::MAX_RANGE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                css_pkg::REG_STATION_COUNT: station_count_reg <= pwdata[css_pkg::COUNT_W-1:0];
                css_pkg::REG_MAX_RANGE:     max_range_reg     <= pwdata[css_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            css_pkg::REG_STATION_COUNT: prdata = css_pkg::APB_DATA_W'(station_count_reg);
            css_pkg::REG_MAX_RANGE:     prdata = css_pkg::APB_DATA_W'(max_range_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.station_count = station_count_reg;
    assign cfg.max_range     = max_range_reg;

    css_front #(
        .STATIONS (STATIONS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_job   (q_in_job)
    );

    css_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_job    (q_in_job),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_job   (q_out_job)
    );

    css_back #(
        .NODES     (NODES),
        .STATIONS  (STATIONS),
        .DIST_BITS (DIST_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (q_out_valid),
        .job_ready (q_out_ready),
        .job       (q_out_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hw/rtl/css_checker.sv
`timescale 1ns / 1ps

module css_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input css_pkg::css_out_t              m_data,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [css_pkg::APB_ADDR_W-1:0] paddr,
    input logic [css_pkg::APB_DATA_W-1:0] prdata
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // An empty answer carries no station and no cost
    a_empty_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.best_station == '0 && m_data.best_cost == '0)
        else $error("result without a station carries data");

    // The station count reads back within its six bits
    a_count_read: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !penable && !pwrite && !paddr[2] |-> prdata[css_pkg::APB_DATA_W-1:6] == '0)
        else $error("station count read back too wide");

endmodule

bind charging_station_search css_checker u_css_checker (.*);
